// File: hdl/uer_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uer_pkg
// Shared widths, codes and distance arithmetic for the echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

    localparam int PERIOD_W  = 22;
    localparam int TRIG_W    = 8;
    localparam int TIMEOUT_W = 16;
    localparam int WIDTH_W   = 16;
    localparam int STATUS_W  = 2;
    localparam int CM_W      = 11;
    localparam int TENTHS_W  = 4;
    localparam int DECI_W    = 14;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 22;

    localparam logic [PERIOD_W-1:0]  RST_REPEAT_PERIOD = 22'd1000000;
    localparam logic [TRIG_W-1:0]    RST_TRIGGER       = 8'd10;
    localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT       = 16'd25000;
    localparam logic [WIDTH_W-1:0]   RST_MAX_VALID     = 16'd50000;

    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VALID     = 2'd3;

    localparam logic [STATUS_W-1:0] ST_VALID  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOECHO = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY   = 2'd2;

    // floor(w/58) = (w * 72316) >> 22 for any 16-bit w
    localparam logic [16:0] DIV58_MUL = 17'd72316;
    // floor(w*5/29) = (w * 5 * 578525) >> 24 for any 16-bit w
    localparam logic [21:0] DECI_MUL  = 22'd2892625;

    function automatic logic [CM_W-1:0] f_dist_cm(input logic [WIDTH_W-1:0] w);
        logic [32:0] prod;
        prod = 33'(w) * 33'(DIV58_MUL);
        return prod[32:22];
    endfunction

    function automatic logic [DECI_W-1:0] f_dist_deci(input logic [WIDTH_W-1:0] w);
        logic [37:0] prod;
        prod = 38'(w) * 38'(DECI_MUL);
        return prod[37:24];
    endfunction

endpackage
`default_nettype wire

// File: hdl/uer_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uer_in_if
// Tick channel: one sampled echo level per transaction.
// ----------------------------------------------------------------------------
interface uer_in_if;
    logic valid;
    logic ready;
    logic echo_level;

    modport source(output valid, output echo_level, input ready);
    modport sink(input valid, input echo_level, output ready);
endinterface
`default_nettype wire

// File: hdl/uer_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uer_out_if
// Result channel: pin drive levels and measurement report per tick.
// ----------------------------------------------------------------------------
interface uer_out_if;
    logic                          valid;
    logic                          ready;
    logic                          trigger_out;
    logic                          led_out;
    logic                          done_res;
    logic [uer_pkg::STATUS_W-1:0]  status;
    logic [uer_pkg::WIDTH_W-1:0]   echo_us;
    logic [uer_pkg::CM_W-1:0]      distance_cm;
    logic [uer_pkg::TENTHS_W-1:0]  distance_tenths;

    modport source(output valid, output trigger_out, output led_out, output done_res,
                   output status, output echo_us, output distance_cm,
                   output distance_tenths, input ready);
    modport sink(input valid, input trigger_out, input led_out, input done_res,
                 input status, input echo_us, input distance_cm,
                 input distance_tenths, output ready);
endinterface
`default_nettype wire

// File: hdl/uer_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uer_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface uer_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [uer_pkg::CFG_IDX_W-1:0]  index;
    logic [uer_pkg::CFG_DAT_W-1:0]  data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/ultrasonic_echo_ranger.sv
// Result: registered; an accepted tick's result transaction is offered in the next cycle.
// Throughput: one tick per cycle; each tick's state update and report come
// from one pass of logic (two parallel constant multipliers for distance).
// Input is stalled only while the result register is full and not taken.
// Reset (synchronous, active low): phase idle, counters zero, no pending
// request, registers at their defaults, result register empty.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Time-of-flight ranger advanced one microsecond tick per input transaction.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    uer_in_if.sink      i_echo,
    uer_out_if.source   o_result,
    uer_cfg_if.sink     i_cfg
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_TRIG  = 3'd1;
    localparam logic [2:0] PH_CHECK = 3'd2;
    localparam logic [2:0] PH_WAIT  = 3'd3;
    localparam logic [2:0] PH_MEAS  = 3'd4;

    localparam int PW = uer_pkg::PERIOD_W;
    localparam int WW = uer_pkg::WIDTH_W;

    logic [PW-1:0]                   r_repeat;
    logic [uer_pkg::TRIG_W-1:0]      r_trigger;
    logic [uer_pkg::TIMEOUT_W-1:0]   r_timeout;
    logic [WW-1:0]                   r_max_valid;

    logic [2:0]     r_phase,  n_phase;
    logic [PW-1:0]  r_period, n_period;
    logic [WW-1:0]  r_count,  n_count;
    logic           r_pending, n_pending;

    logic                          r_out_valid;
    logic                          r_trig_out,  n_trig_out;
    logic                          r_led,       n_led;
    logic                          r_done,      n_done;
    logic [uer_pkg::STATUS_W-1:0]  r_status,    n_status;
    logic [WW-1:0]                 r_echo_us,   n_echo_us;
    logic [uer_pkg::CM_W-1:0]      r_cm,        n_cm;
    logic [uer_pkg::TENTHS_W-1:0]  r_tenths,    n_tenths;

    logic                          in_fire;
    logic                          echo;
    logic [PW-1:0]                 rep_eff;
    logic [uer_pkg::TRIG_W-1:0]    trig_eff;
    logic [PW:0]                   period_inc;
    logic [2:0]                    ph;
    logic [WW:0]                   low_next;
    logic [WW:0]                   high_next;
    logic [WW:0]                   fin_width;
    logic                          fin;
    logic [WW-1:0]                 trig_next;
    logic [uer_pkg::CM_W-1:0]      dist_cm;
    logic [uer_pkg::DECI_W-1:0]    dist_deci;
    logic [uer_pkg::DECI_W-1:0]    cm_x10;
    logic [uer_pkg::DECI_W-1:0]    tenths_full;

    assign in_fire        = i_echo.valid & i_echo.ready;
    assign i_echo.ready   = ~r_out_valid | o_result.ready;
    assign i_cfg.ready    = 1'b1;
    assign echo           = i_echo.echo_level;

    assign rep_eff    = (r_repeat == '0) ? PW'(1) : r_repeat;
    assign trig_eff   = (r_trigger == '0) ? uer_pkg::TRIG_W'(1) : r_trigger;
    assign period_inc = {1'b0, r_period} + (PW+1)'(1);

    // distance from the stored high count: cm = w/58, tenths = w*5/29 - 10*cm
    assign dist_cm     = uer_pkg::f_dist_cm(r_count);
    assign dist_deci   = uer_pkg::f_dist_deci(r_count);
    assign cm_x10      = (uer_pkg::DECI_W'(dist_cm) << 3) + (uer_pkg::DECI_W'(dist_cm) << 1);
    assign tenths_full = dist_deci - cm_x10;

    always_comb begin
        n_pending = r_pending | (r_period == '0);
        n_period  = (period_inc >= {1'b0, rep_eff}) ? '0 : period_inc[PW-1:0];

        ph      = r_phase;
        n_count = r_count;
        if (r_phase == PH_IDLE && n_pending) begin
            n_pending = 1'b0;
            ph        = PH_TRIG;
            n_count   = '0;
        end
        n_phase = ph;

        low_next  = (ph == PH_WAIT) ? ({1'b0, n_count} + (WW+1)'(1)) : (WW+1)'(1);
        high_next = (ph == PH_MEAS) ? ({1'b0, n_count} + (WW+1)'(1)) : (WW+1)'(1);
        trig_next = n_count + WW'(1);

        n_trig_out = 1'b0;
        n_led      = 1'b0;
        fin        = 1'b0;
        n_status   = uer_pkg::ST_VALID;
        fin_width  = '0;

        case (ph)
            PH_TRIG: begin
                n_trig_out = 1'b1;
                n_led      = 1'b1;
                if (trig_next >= WW'(trig_eff)) begin
                    n_phase = PH_CHECK;
                    n_count = '0;
                end else begin
                    n_count = trig_next;
                end
            end
            PH_CHECK, PH_WAIT: begin
                if (ph == PH_CHECK && echo) begin
                    fin      = 1'b1;
                    n_status = uer_pkg::ST_BUSY;
                end else if (!echo) begin
                    if (low_next > (WW+1)'(r_timeout)) begin
                        fin      = 1'b1;
                        n_status = uer_pkg::ST_NOECHO;
                    end else begin
                        n_phase = PH_WAIT;
                        n_count = low_next[WW-1:0];
                        n_led   = 1'b1;
                    end
                end else if (high_next > (WW+1)'(r_timeout)) begin
                    fin       = 1'b1;
                    n_status  = uer_pkg::ST_NOECHO;
                    fin_width = high_next;
                end else begin
                    n_phase = PH_MEAS;
                    n_count = high_next[WW-1:0];
                    n_led   = 1'b1;
                end
            end
            PH_MEAS: begin
                if (echo) begin
                    if (high_next > (WW+1)'(r_timeout)) begin
                        fin       = 1'b1;
                        n_status  = uer_pkg::ST_NOECHO;
                        fin_width = high_next;
                    end else begin
                        n_count = high_next[WW-1:0];
                        n_led   = 1'b1;
                    end
                end else begin
                    fin       = 1'b1;
                    fin_width = {1'b0, n_count};
                    n_status  = (n_count != '0 && n_count < r_max_valid) ?
                                uer_pkg::ST_VALID : uer_pkg::ST_NOECHO;
                end
            end
            PH_IDLE: begin
                n_count = n_count;
            end
            default: begin
                n_phase = PH_IDLE;
                n_count = '0;
            end
        endcase

        if (fin) begin
            n_phase = PH_IDLE;
            n_count = '0;
        end
        n_done    = fin;
        n_echo_us = fin_width[WW] ? '1 : fin_width[WW-1:0];
        // valid status only arises in the measure phase, where r_count is the width
        if (fin && n_status == uer_pkg::ST_VALID) begin
            n_cm     = dist_cm;
            n_tenths = tenths_full[uer_pkg::TENTHS_W-1:0];
        end else begin
            n_cm     = '0;
            n_tenths = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat    <= uer_pkg::RST_REPEAT_PERIOD;
            r_trigger   <= uer_pkg::RST_TRIGGER;
            r_timeout   <= uer_pkg::RST_TIMEOUT;
            r_max_valid <= uer_pkg::RST_MAX_VALID;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                uer_pkg::REG_REPEAT_PERIOD: r_repeat    <= i_cfg.data[PW-1:0];
                uer_pkg::REG_TRIGGER:       r_trigger   <= i_cfg.data[uer_pkg::TRIG_W-1:0];
                uer_pkg::REG_TIMEOUT:       r_timeout   <= i_cfg.data[uer_pkg::TIMEOUT_W-1:0];
                uer_pkg::REG_MAX_VALID:     r_max_valid <= i_cfg.data[WW-1:0];
                default: begin
                    r_repeat <= r_repeat;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_period    <= '0;
            r_count     <= '0;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_phase     <= n_phase;
            r_period    <= n_period;
            r_count     <= n_count;
            r_pending   <= n_pending;
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_trig_out <= n_trig_out;
            r_led      <= n_led;
            r_done     <= n_done;
            r_status   <= n_status;
            r_echo_us  <= n_echo_us;
            r_cm       <= n_cm;
            r_tenths   <= n_tenths;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.trigger_out     = r_trig_out;
    assign o_result.led_out         = r_led;
    assign o_result.done_res        = r_done;
    assign o_result.status          = r_status;
    assign o_result.echo_us         = r_echo_us;
    assign o_result.distance_cm     = r_cm;
    assign o_result.distance_tenths = r_tenths;

endmodule
`default_nettype wire

// File: hdl/uer_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uer_checker
// Port-level checks on the ranger's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module uer_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic                          i_trigger_out,
    input wire logic                          i_led_out,
    input wire logic                          i_done_res,
    input wire logic [uer_pkg::STATUS_W-1:0]  i_status,
    input wire logic [uer_pkg::WIDTH_W-1:0]   i_echo_us,
    input wire logic [uer_pkg::CM_W-1:0]      i_distance_cm,
    input wire logic [uer_pkg::TENTHS_W-1:0]  i_distance_tenths
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_echo_us) && $stable(i_done_res))
        else $error("result changed while stalled");

    a_report_pins_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_done_res |-> !i_led_out && !i_trigger_out)
        else $error("led or trigger high on report transaction");

    a_trigger_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_trigger_out |-> i_led_out)
        else $error("trigger without led");

    a_idle_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_done_res |-> i_status == uer_pkg::ST_VALID && i_echo_us == '0)
        else $error("report fields set without done");

    a_distance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_distance_tenths <= uer_pkg::TENTHS_W'(9)
            && ((i_distance_cm == '0 && i_distance_tenths == '0)
                || (i_done_res && i_status == uer_pkg::ST_VALID)))
        else $error("distance out of range or without valid status");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_result.valid),
    .i_out_ready       (o_result.ready),
    .i_trigger_out     (o_result.trigger_out),
    .i_led_out         (o_result.led_out),
    .i_done_res        (o_result.done_res),
    .i_status          (o_result.status),
    .i_echo_us         (o_result.echo_us),
    .i_distance_cm     (o_result.distance_cm),
    .i_distance_tenths (o_result.distance_tenths)
);
`default_nettype wire

// File: test/tb_ultrasonic_echo_ranger.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ultrasonic_echo_ranger
// Self-checking bench for the echo ranger. Echo ticks come from a queue through
// a clocked driver. A clocked monitor predicts every result from the accepted
// tick and compares it, field by field, with the next result transaction.
// Registers are reprogrammed between phases: zero and full-scale values, a
// stall-free stretch with the full-scale settings, random small settings and a longest-period run.
// ----------------------------------------------------------------------------
module tb_ultrasonic_echo_ranger;

    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_PRINTS  = 100;
    localparam int DAT_W       = uer_pkg::CFG_DAT_W;

    typedef enum logic [2:0] {
        RNG_IDLE,
        RNG_TRIG,
        RNG_CHECK,
        RNG_WAIT,
        RNG_MEAS
    } t_rng_phase;

    typedef struct packed {
        logic                         trigger_out;
        logic                         led_out;
        logic                         done_res;
        logic [uer_pkg::STATUS_W-1:0] status;
        logic [uer_pkg::WIDTH_W-1:0]  echo_us;
        logic [uer_pkg::CM_W-1:0]     distance_cm;
        logic [uer_pkg::TENTHS_W-1:0] distance_tenths;
    } t_tick_result;

    logic i_clk;
    logic i_rst_n;
    bit   steady;

    uer_in_if  echo_if ();
    uer_out_if res_if ();
    uer_cfg_if cfg_if ();

    ultrasonic_echo_ranger DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_echo   (echo_if),
        .o_result (res_if),
        .i_cfg    (cfg_if)
    );

    // Predicted block state and register copies
    t_rng_phase                    rng_phase     = RNG_IDLE;
    logic [uer_pkg::PERIOD_W-1:0]  period_cnt    = '0;
    int unsigned                   phase_cnt     = 0;
    bit                            req_pending   = 1'b0;
    logic [uer_pkg::PERIOD_W-1:0]  cfg_repeat    = uer_pkg::RST_REPEAT_PERIOD;
    logic [uer_pkg::TRIG_W-1:0]    cfg_trigger   = uer_pkg::RST_TRIGGER;
    logic [uer_pkg::TIMEOUT_W-1:0] cfg_timeout   = uer_pkg::RST_TIMEOUT;
    logic [uer_pkg::WIDTH_W-1:0]   cfg_max_valid = uer_pkg::RST_MAX_VALID;

    bit           pending_echo[$];
    t_tick_result expected_ticks[$];
    int unsigned  error_count  = 0;
    int unsigned  results_seen = 0;
    int unsigned  quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTS) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
        error_count++;
    endtask

    function automatic t_tick_result close_ping(input logic [uer_pkg::STATUS_W-1:0] st,
                                                input int unsigned width);
        t_tick_result r;
        int unsigned  w;
        int unsigned  deci;
        r = '0;
        w = (width > 65535) ? 65535 : width;
        rng_phase = RNG_IDLE;
        phase_cnt = 0;
        r.done_res = 1'b1;
        r.status   = st;
        r.echo_us  = uer_pkg::WIDTH_W'(w);
        if (st == uer_pkg::ST_VALID) begin
            deci = w * 10 / 58;
            r.distance_cm     = uer_pkg::CM_W'(deci / 10);
            r.distance_tenths = uer_pkg::TENTHS_W'(deci % 10);
        end
        return r;
    endfunction

    function automatic t_tick_result count_high();
        t_tick_result r;
        int unsigned  n;
        r = '0;
        n = phase_cnt + 1;
        if (n > cfg_timeout) begin
            r = close_ping(uer_pkg::ST_NOECHO, n);
        end else begin
            phase_cnt = n;
            r.led_out = 1'b1;
        end
        return r;
    endfunction

    function automatic t_tick_result advance_ranger(input bit echo);
        t_tick_result r;
        int unsigned  rep;
        int unsigned  trig;
        int unsigned  p;
        int unsigned  n;
        r = '0;
        rep  = (cfg_repeat == 0) ? 1 : cfg_repeat;
        trig = (cfg_trigger == 0) ? 1 : cfg_trigger;
        if (period_cnt == 0) begin
            req_pending = 1'b1;
        end
        p = period_cnt + 1;
        period_cnt = (p >= rep) ? '0 : uer_pkg::PERIOD_W'(p);
        if (rng_phase == RNG_IDLE && req_pending) begin
            req_pending = 1'b0;
            rng_phase   = RNG_TRIG;
            phase_cnt   = 0;
        end
        case (rng_phase)
            RNG_TRIG: begin
                r.trigger_out = 1'b1;
                r.led_out     = 1'b1;
                phase_cnt++;
                if (phase_cnt >= trig) begin
                    rng_phase = RNG_CHECK;
                    phase_cnt = 0;
                end
            end
            RNG_CHECK, RNG_WAIT: begin
                if (rng_phase == RNG_CHECK && echo) begin
                    r = close_ping(uer_pkg::ST_BUSY, 0);
                end else begin
                    // a low check tick is already the first waiting tick
                    if (rng_phase == RNG_CHECK) begin
                        rng_phase = RNG_WAIT;
                        phase_cnt = 0;
                    end
                    if (!echo) begin
                        n = phase_cnt + 1;
                        if (n > cfg_timeout) begin
                            r = close_ping(uer_pkg::ST_NOECHO, 0);
                        end else begin
                            phase_cnt = n;
                            r.led_out = 1'b1;
                        end
                    end else begin
                        rng_phase = RNG_MEAS;
                        phase_cnt = 0;
                        r = count_high();
                    end
                end
            end
            RNG_MEAS: begin
                if (echo) begin
                    r = count_high();
                end else if (phase_cnt > 0 && phase_cnt < cfg_max_valid) begin
                    r = close_ping(uer_pkg::ST_VALID, phase_cnt);
                end else begin
                    r = close_ping(uer_pkg::ST_NOECHO, phase_cnt);
                end
            end
            default: begin
                rng_phase = RNG_IDLE;
                phase_cnt = 0;
            end
        endcase
        return r;
    endfunction

    task automatic check_tick(input t_tick_result got, input t_tick_result want);
        if (got.trigger_out !== want.trigger_out)
            report_mismatch($sformatf("result %0d: trigger_out %0b, expected %0b",
                                      results_seen, got.trigger_out, want.trigger_out));
        if (got.led_out !== want.led_out)
            report_mismatch($sformatf("result %0d: led_out %0b, expected %0b",
                                      results_seen, got.led_out, want.led_out));
        if (got.done_res !== want.done_res)
            report_mismatch($sformatf("result %0d: done_res %0b, expected %0b",
                                      results_seen, got.done_res, want.done_res));
        if (got.status !== want.status)
            report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                      results_seen, got.status, want.status));
        if (got.echo_us !== want.echo_us)
            report_mismatch($sformatf("result %0d: echo_us %0d, expected %0d",
                                      results_seen, got.echo_us, want.echo_us));
        if (got.distance_cm !== want.distance_cm)
            report_mismatch($sformatf("result %0d: distance_cm %0d, expected %0d",
                                      results_seen, got.distance_cm, want.distance_cm));
        if (got.distance_tenths !== want.distance_tenths)
            report_mismatch($sformatf("result %0d: distance_tenths %0d, expected %0d",
                                      results_seen, got.distance_tenths,
                                      want.distance_tenths));
    endtask

    // Tick driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            echo_if.valid <= 1'b0;
        end else if (!echo_if.valid || echo_if.ready) begin
            if (pending_echo.size() != 0 && (steady || $urandom_range(0, 99) >= 22)) begin
                echo_if.valid      <= 1'b1;
                echo_if.echo_level <= pending_echo.pop_front();
            end else begin
                echo_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        res_if.ready <= steady || ($urandom_range(0, 99) >= 22);
    end

    // Monitor: predict on accepted ticks, check result transactions
    always @(posedge i_clk) begin : monitor
        t_tick_result got;
        if (i_rst_n) begin
            if (echo_if.valid && echo_if.ready) begin
                expected_ticks.push_back(advance_ranger(echo_if.echo_level));
            end
            if (res_if.valid && res_if.ready) begin
                results_seen++;
                got.trigger_out     = res_if.trigger_out;
                got.led_out         = res_if.led_out;
                got.done_res        = res_if.done_res;
                got.status          = res_if.status;
                got.echo_us         = res_if.echo_us;
                got.distance_cm     = res_if.distance_cm;
                got.distance_tenths = res_if.distance_tenths;
                if (expected_ticks.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              results_seen));
                end else begin
                    check_tick(got, expected_ticks.pop_front());
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (echo_if.valid && echo_if.ready) || (res_if.valid && res_if.ready)
            || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic apply_reg(input logic [uer_pkg::CFG_IDX_W-1:0] idx,
                             input logic [DAT_W-1:0] val);
        case (idx)
            uer_pkg::REG_REPEAT_PERIOD: cfg_repeat    = val[uer_pkg::PERIOD_W-1:0];
            uer_pkg::REG_TRIGGER:       cfg_trigger   = val[uer_pkg::TRIG_W-1:0];
            uer_pkg::REG_TIMEOUT:       cfg_timeout   = val[uer_pkg::TIMEOUT_W-1:0];
            uer_pkg::REG_MAX_VALID:     cfg_max_valid = val[uer_pkg::WIDTH_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [DAT_W-1:0] rep_d,
                                input logic [DAT_W-1:0] trig_d,
                                input logic [DAT_W-1:0] tmo_d,
                                input logic [DAT_W-1:0] maxv_d);
        logic [DAT_W-1:0]              vals [4];
        logic [uer_pkg::CFG_IDX_W-1:0] idxs [4];
        int k;
        vals = '{rep_d, trig_d, tmo_d, maxv_d};
        idxs = '{uer_pkg::REG_REPEAT_PERIOD, uer_pkg::REG_TRIGGER,
                 uer_pkg::REG_TIMEOUT, uer_pkg::REG_MAX_VALID};
        @(posedge i_clk);
        for (k = 0; k < 4; k++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idxs[k];
            cfg_if.data  <= vals[k];
            do @(posedge i_clk); while (!cfg_if.ready);
            apply_reg(idxs[k], vals[k]);
        end
        cfg_if.valid <= 1'b0;
    endtask

    task automatic fill_level(input bit lvl, input int unsigned n);
        repeat (n) pending_echo.push_back(lvl);
    endtask

    task automatic fill_noise(input int unsigned n);
        repeat (n) pending_echo.push_back(1'($urandom_range(0, 1)));
    endtask

    task automatic fill_bits(input logic [15:0] bits, input int n);
        int k;
        for (k = 0; k < n; k++) pending_echo.push_back(bits[k]);
    endtask

    // Alternating low/high runs, some sized around the timeout and the width limit, with noise bursts
    task automatic queue_echo_shapes(input int unsigned n_items, input int unsigned tmo,
                                     input int unsigned maxv, input int unsigned span);
        int unsigned added;
        int unsigned len;
        bit          lvl;
        added = 0;
        lvl   = 1'b0;
        while (added < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                len = $urandom_range(1, 5);
                fill_noise(len);
            end else begin
                case ($urandom_range(0, 3))
                    0: len = $urandom_range(1, 4);
                    1: len = $urandom_range((tmo > 1) ? tmo - 1 : 1, tmo + 2);
                    2: len = $urandom_range((maxv > 1) ? maxv - 1 : 1, maxv + 1);
                    default: len = $urandom_range(1, span);
                endcase
                fill_level(lvl, len);
                lvl = !lvl;
            end
            added += len;
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_echo.size() != 0 || echo_if.valid || expected_ticks.size() != 0);
    endtask

    initial begin : stimulus
        int unsigned rep;
        int unsigned trig;
        int unsigned tmo;
        int unsigned maxv;
        int          ph;
        i_rst_n            = 1'b0;
        steady             = 1'b0;
        echo_if.valid      = 1'b0;
        echo_if.echo_level = 1'b0;
        res_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = uer_pkg::REG_REPEAT_PERIOD;
        cfg_if.data        = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Defaults: ten trigger ticks, then echo already high at the check
        @(negedge i_clk);
        fill_bits(16'b1_0100_0101_0101, 13);
        wait_drained();

        // All registers zero: request every tick, one-tick trigger, instant timeout
        program_regs('0, '0, '0, '0);
        @(negedge i_clk);
        fill_bits(16'b0_1100_0111, 9);
        wait_drained();

        // Full-scale trigger, timeout and width limit with no stalls:
        // a short valid width, then busy
        program_regs(DAT_W'(1), DAT_W'(255), DAT_W'(16'hFFFF), DAT_W'(16'hFFFF));
        @(negedge i_clk);
        steady = 1'b1;
        fill_noise(255);
        fill_level(1'b0, 4);
        fill_level(1'b1, 40);
        fill_level(1'b0, 1);
        fill_noise(255);
        fill_level(1'b1, 1);
        fill_level(1'b0, 3);
        wait_drained();
        steady = 1'b0;

        // Small random settings; junk above the trigger, timeout and width-limit fields
        for (ph = 0; ph < 4; ph++) begin
            rep  = $urandom_range(6, 120);
            trig = $urandom_range(0, 6);
            tmo  = $urandom_range(1, 30);
            maxv = $urandom_range(1, 36);
            program_regs(DAT_W'(rep),
                         DAT_W'(($urandom() << uer_pkg::TRIG_W) | trig),
                         DAT_W'(($urandom() << uer_pkg::TIMEOUT_W) | tmo),
                         DAT_W'(($urandom() << uer_pkg::WIDTH_W) | maxv));
            @(negedge i_clk);
            queue_echo_shapes(150, tmo, maxv, 2 * tmo + trig + 4);
            wait_drained();
        end

        // Longest period with a timeout and width limit of 1000
        trig = $urandom_range(1, 255);
        program_regs(DAT_W'(22'h3FFFFF), DAT_W'(trig), DAT_W'(1000), DAT_W'(1000));
        @(negedge i_clk);
        fill_noise(100);
        wait_drained();

        repeat (8) @(posedge i_clk);
        if (expected_ticks.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_ticks.size()));
        end
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/uer_pkg.sv
hdl/uer_in_if.sv
hdl/uer_out_if.sv
hdl/uer_cfg_if.sv
hdl/ultrasonic_echo_ranger.sv
hdl/uer_checker.sv
test/tb_ultrasonic_echo_ranger.sv
